/* sv/rotated_text_box_decode_defines.svh */
// ----------------------------------------------------------------------------
// rotated_text_box_decode_defines.svh
// Assertion macros shared by the rotated text box decoder.
// ----------------------------------------------------------------------------
`ifndef ROTATED_TEXT_BOX_DECODE_DEFINES_SVH
`define ROTATED_TEXT_BOX_DECODE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RTBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RTBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rtbd_pkg.sv */
// ----------------------------------------------------------------------------
// rtbd_pkg
// Widths, constants, types and helpers of the rotated text box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtbd_pkg;

	// field widths
	localparam int COORD_W = 8;
	localparam int SCORE_W = 16;
	localparam int DIST_W  = 16;
	localparam int ANGLE_W = 16;
	localparam int CTR_W   = 18;
	localparam int SIZE_W  = 17;
	localparam int DEG_W   = 16;

	// stride
	localparam int CELL_STRIDE_DEF = 4;
	localparam int CELL_STRIDE_MAX = 32;

	// CORDIC
	localparam int CORDIC_ITERS     = 16;
	localparam int CORDIC_PER_STAGE = 4;
	localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;
	localparam int CW = 19;                 // x/y, Q.16
	localparam int ZW = 20;                 // residual angle, Q.16
	localparam logic signed [ZW-1:0] Q16_PI      = 20'sd205887;
	localparam logic signed [ZW-1:0] Q16_HALF_PI = 20'sd102944;
	localparam logic signed [CW-1:0] CORDIC_K    = 19'sd39797;

	// products and accumulators
	localparam int PW         = CW + SIZE_W;  // cos/sin times distance diff
	localparam int ACC_W      = 38;           // Q.21 center sum, stride up to 32
	localparam int BASE_SHIFT = 21;
	localparam int CTR_SHIFT  = 17;
	localparam logic signed [ACC_W-1:0] ACC_HALF = 38'sd65536;
	localparam logic signed [ACC_W-1:0] CTR_MAX  = 38'sd131071;
	localparam logic signed [ACC_W-1:0] CTR_MIN  = -38'sd131072;

	// degrees: -a * 180/pi/64 in Q.16
	localparam int DEG_PW = 35;
	localparam int DEG_SHIFT = 16;
	localparam logic signed [17:0] DEG_SCALE = 18'sd58671;
	localparam logic signed [DEG_PW-1:0] DEG_HALF = 35'sd32768;
	localparam logic signed [DEG_PW-1:0] DEG_MAX  = 35'sd32767;
	localparam logic signed [DEG_PW-1:0] DEG_MIN  = -35'sd32768;

	// register file
	localparam int ADDR_W = 3;
	localparam int IDX_W  = ADDR_W - 2;
	localparam logic [IDX_W-1:0] REG_SCORE_THRESHOLD = '0;
	localparam logic [SCORE_W-1:0] THR_RESET = 16'd32768;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} rtbd_rot_t;

	typedef struct packed {
		logic [COORD_W-1:0]       col;
		logic [COORD_W-1:0]       row;
		logic [SCORE_W-1:0]       score;
		logic signed [SIZE_W-1:0] d_rl;    // right - left
		logic signed [SIZE_W-1:0] d_bt;    // bottom - top
		logic signed [SIZE_W-1:0] w;
		logic signed [SIZE_W-1:0] h;
		logic signed [DEG_PW-1:0] deg_p;
	} rtbd_meta_t;

	// atan(2^-i) in Q.16
	function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			4'd0:    v = 20'sd51472;
			4'd1:    v = 20'sd30386;
			4'd2:    v = 20'sd16055;
			4'd3:    v = 20'sd8150;
			4'd4:    v = 20'sd4091;
			4'd5:    v = 20'sd2047;
			4'd6:    v = 20'sd1024;
			4'd7:    v = 20'sd512;
			4'd8:    v = 20'sd256;
			4'd9:    v = 20'sd128;
			4'd10:   v = 20'sd64;
			4'd11:   v = 20'sd32;
			4'd12:   v = 20'sd16;
			4'd13:   v = 20'sd8;
			4'd14:   v = 20'sd4;
			4'd15:   v = 20'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [CTR_W-1:0] sat_ctr(input logic signed [ACC_W-1:0] v);
		logic signed [CTR_W-1:0] r;
		if (v > CTR_MAX) begin
			r = CTR_MAX[CTR_W-1:0];
		end else if (v < CTR_MIN) begin
			r = CTR_MIN[CTR_W-1:0];
		end else begin
			r = v[CTR_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DEG_W-1:0] sat_deg(input logic signed [DEG_PW-1:0] v);
		logic signed [DEG_W-1:0] r;
		if (v > DEG_MAX) begin
			r = DEG_MAX[DEG_W-1:0];
		end else if (v < DEG_MIN) begin
			r = DEG_MIN[DEG_W-1:0];
		end else begin
			r = v[DEG_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/rtbd_if.sv */
// ----------------------------------------------------------------------------
// rtbd_if
// Valid/ready channels: feature-map cell in, decoded box out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtbd_cell_if import rtbd_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [COORD_W-1:0]        cell_column;
	logic [COORD_W-1:0]        cell_row;
	logic [SCORE_W-1:0]        cell_score;
	logic signed [DIST_W-1:0]  dist_top;
	logic signed [DIST_W-1:0]  dist_right;
	logic signed [DIST_W-1:0]  dist_bottom;
	logic signed [DIST_W-1:0]  dist_left;
	logic signed [ANGLE_W-1:0] box_angle_rad;

	modport source (
		output valid, cell_column, cell_row, cell_score,
		output dist_top, dist_right, dist_bottom, dist_left, box_angle_rad,
		input  ready
	);
	modport sink (
		input  valid, cell_column, cell_row, cell_score,
		input  dist_top, dist_right, dist_bottom, dist_left, box_angle_rad,
		output ready
	);
endinterface

interface rtbd_box_if import rtbd_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [CTR_W-1:0]  center_x;
	logic signed [CTR_W-1:0]  center_y;
	logic signed [SIZE_W-1:0] box_width;
	logic signed [SIZE_W-1:0] box_height;
	logic signed [DEG_W-1:0]  angle_degrees;
	logic [SCORE_W-1:0]       kept_score;

	modport source (
		output valid, center_x, center_y, box_width, box_height,
		output angle_degrees, kept_score,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, box_width, box_height,
		input  angle_degrees, kept_score,
		output ready
	);
endinterface

`default_nettype wire

/* sv/rtbd_front.sv */
// ----------------------------------------------------------------------------
// rtbd_front
// Stage 1: score gate, angle range reduction, edge sums and differences,
// degree product.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbd_front import rtbd_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	rtbd_cell_if.sink           cell_in,
	input  wire logic [SCORE_W-1:0] thr,
	output logic                out_valid,
	output rtbd_rot_t           out_rot,
	output rtbd_meta_t          out_meta,
	input  wire logic           out_ready
);

	logic                     v_s1;
	rtbd_rot_t                rot_s1;
	rtbd_meta_t               meta_s1;
	logic                     adv;
	logic                     keep;
	logic signed [ZW-1:0]     z_full;
	rtbd_rot_t                rot_d;
	rtbd_meta_t               meta_d;
	logic signed [SIZE_W-1:0] neg_a;

	assign adv           = !v_s1 || out_ready;
	assign cell_in.ready = adv;
	assign keep          = cell_in.cell_score >= thr;

	always_comb begin
		z_full = ZW'(cell_in.box_angle_rad) <<< 3;
		rot_d.x = CORDIC_K;
		rot_d.y = '0;
		if (z_full > Q16_HALF_PI) begin
			rot_d.z   = z_full - Q16_PI;
			rot_d.neg = 1'b1;
		end else if (z_full < -Q16_HALF_PI) begin
			rot_d.z   = z_full + Q16_PI;
			rot_d.neg = 1'b1;
		end else begin
			rot_d.z   = z_full;
			rot_d.neg = 1'b0;
		end

		neg_a        = -SIZE_W'(cell_in.box_angle_rad);
		meta_d.col   = cell_in.cell_column;
		meta_d.row   = cell_in.cell_row;
		meta_d.score = cell_in.cell_score;
		meta_d.d_rl  = SIZE_W'(cell_in.dist_right) - SIZE_W'(cell_in.dist_left);
		meta_d.d_bt  = SIZE_W'(cell_in.dist_bottom) - SIZE_W'(cell_in.dist_top);
		meta_d.w     = SIZE_W'(cell_in.dist_right) + SIZE_W'(cell_in.dist_left);
		meta_d.h     = SIZE_W'(cell_in.dist_top) + SIZE_W'(cell_in.dist_bottom);
		meta_d.deg_p = neg_a * DEG_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cell_in.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cell_in.valid) begin
			rot_s1  <= rot_d;
			meta_s1 <= meta_d;
		end
	end

	assign out_valid = v_s1;
	assign out_rot   = rot_s1;
	assign out_meta  = meta_s1;

endmodule

`default_nettype wire

/* sv/rtbd_cordic_stage.sv */
// ----------------------------------------------------------------------------
// rtbd_cordic_stage
// One register stage of rotation-mode CORDIC, CORDIC_PER_STAGE iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbd_cordic_stage import rtbd_pkg::*; #(
	parameter int FIRST_ITER = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire rtbd_rot_t  in_rot,
	input  wire rtbd_meta_t in_meta,
	output logic            in_ready,
	output logic            out_valid,
	output rtbd_rot_t       out_rot,
	output rtbd_meta_t      out_meta,
	input  wire logic       out_ready
);

	logic       v_q;
	rtbd_rot_t  rot_q;
	rtbd_meta_t meta_q;
	rtbd_rot_t  rot_d;
	logic       adv;

	assign adv      = !v_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		rot_d = in_rot;
		for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
			dx = rot_d.y >>> (FIRST_ITER + k);
			dy = rot_d.x >>> (FIRST_ITER + k);
			if (!rot_d.z[ZW-1]) begin
				rot_d.x = rot_d.x - dx;
				rot_d.y = rot_d.y + dy;
				rot_d.z = rot_d.z - atan_q16(4'(FIRST_ITER + k));
			end else begin
				rot_d.x = rot_d.x + dx;
				rot_d.y = rot_d.y - dy;
				rot_d.z = rot_d.z + atan_q16(4'(FIRST_ITER + k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			rot_q  <= rot_d;
			meta_q <= in_meta;
		end
	end

	assign out_valid = v_q;
	assign out_rot   = rot_q;
	assign out_meta  = meta_q;

endmodule

`default_nettype wire

/* sv/rtbd_back.sv */
// ----------------------------------------------------------------------------
// rtbd_back
// Stages 6-8: sign fix and four products, center sums, rounding and
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtbd_back import rtbd_pkg::*; #(
	parameter int unsigned CELL_STRIDE = CELL_STRIDE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire rtbd_rot_t  in_rot,
	input  wire rtbd_meta_t in_meta,
	output logic            in_ready,
	rtbd_box_if.source      box_out
);

	// stage 6
	logic                     v_s6;
	logic signed [PW-1:0]     p_c_rl_s6, p_s_bt_s6, p_c_bt_s6, p_s_rl_s6;
	rtbd_meta_t               meta_s6;
	// stage 7
	logic                     v_s7;
	logic signed [ACC_W-1:0]  x2_s7, y2_s7;
	logic signed [DEG_PW-1:0] deg_s7;
	logic signed [SIZE_W-1:0] w_s7, h_s7;
	logic [SCORE_W-1:0]       score_s7;
	// stage 8 (output)
	logic                     v_s8;
	logic signed [CTR_W-1:0]  cx_s8, cy_s8;
	logic signed [SIZE_W-1:0] w_s8, h_s8;
	logic signed [DEG_W-1:0]  deg_s8;
	logic [SCORE_W-1:0]       score_s8;

	logic                     rdy6, rdy7, rdy8;
	logic signed [CW-1:0]     cos_v, sin_v;
	logic signed [ACC_W-1:0]  base_x, base_y;
	logic signed [ACC_W-1:0]  xr, yr;
	logic signed [DEG_PW-1:0] deg_r;

	assign rdy8     = !v_s8 || box_out.ready;
	assign rdy7     = !v_s7 || rdy8;
	assign rdy6     = !v_s6 || rdy7;
	assign in_ready = rdy6;

	assign cos_v = in_rot.neg ? -in_rot.x : in_rot.x;
	assign sin_v = in_rot.neg ? -in_rot.y : in_rot.y;

	assign base_x = (ACC_W'(CELL_STRIDE) * ACC_W'(meta_s6.col)) <<< BASE_SHIFT;
	assign base_y = (ACC_W'(CELL_STRIDE) * ACC_W'(meta_s6.row)) <<< BASE_SHIFT;

	assign xr    = (x2_s7 + ACC_HALF) >>> CTR_SHIFT;
	assign yr    = (y2_s7 + ACC_HALF) >>> CTR_SHIFT;
	assign deg_r = (deg_s7 + DEG_HALF) >>> DEG_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy6) begin
				v_s6 <= in_valid;
			end
			if (rdy7) begin
				v_s7 <= v_s6;
			end
			if (rdy8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && in_valid) begin
			p_c_rl_s6 <= cos_v * in_meta.d_rl;
			p_s_bt_s6 <= sin_v * in_meta.d_bt;
			p_c_bt_s6 <= cos_v * in_meta.d_bt;
			p_s_rl_s6 <= sin_v * in_meta.d_rl;
			meta_s6   <= in_meta;
		end
		if (rdy7 && v_s6) begin
			// x: stride*col + c*(r-l) + s*(b-t); y: stride*row + c*(b-t) - s*(r-l)
			x2_s7    <= base_x + ACC_W'(p_c_rl_s6) + ACC_W'(p_s_bt_s6);
			y2_s7    <= base_y + ACC_W'(p_c_bt_s6) - ACC_W'(p_s_rl_s6);
			deg_s7   <= meta_s6.deg_p;
			w_s7     <= meta_s6.w;
			h_s7     <= meta_s6.h;
			score_s7 <= meta_s6.score;
		end
		if (rdy8 && v_s7) begin
			cx_s8    <= sat_ctr(xr);
			cy_s8    <= sat_ctr(yr);
			deg_s8   <= sat_deg(deg_r);
			w_s8     <= w_s7;
			h_s8     <= h_s7;
			score_s8 <= score_s7;
		end
	end

	assign box_out.valid         = v_s8;
	assign box_out.center_x      = cx_s8;
	assign box_out.center_y      = cy_s8;
	assign box_out.box_width     = w_s8;
	assign box_out.box_height    = h_s8;
	assign box_out.angle_degrees = deg_s8;
	assign box_out.kept_score    = score_s8;

endmodule

`default_nettype wire

/* sv/rotated_text_box_decode.sv */
// ----------------------------------------------------------------------------
// rotated_text_box_decode
// Decodes one text-score feature-map cell into a rotated box.
// ----------------------------------------------------------------------------
// Usage:
//  cell_in  - valid/ready channel, one cell per transaction (column, row,
//             score, four Q11.4 edge distances, Q2.13 angle).
//  box_out  - valid/ready channel, one box per kept cell (Q13.4 center,
//             Q12.4 width/height, Q8.7 negated angle in degrees, score).
//  APB      - score_threshold at byte address 0; written while idle.
//  A cell whose score is below the threshold produces no transaction on
//  box_out; its slot in the pipe becomes a bubble.
//  Path from an accepted cell to its box on box_out: gate/reduce, four
//  CORDIC stages of four iterations, products, sums, round/saturate.
//  Throughput: one cell per cycle while box_out.ready is high, set by the
//  eight register stages each taking a new item every clock unless stalled.
//  Reset: arst_n clears every stage valid and loads threshold 32768.
//  Stall: when box_out.ready is low the final register holds; bubbles in
//  earlier stages still fill, and cell_in.ready drops only once every stage
//  holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotated_text_box_decode_defines.svh"

module rotated_text_box_decode import rtbd_pkg::*; #(
	parameter int unsigned CELL_STRIDE = CELL_STRIDE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rtbd_cell_if.sink              cell_in,
	rtbd_box_if.source             box_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// configuration register
	logic [SCORE_W-1:0] thr_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_SCORE_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[SCORE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_SCORE_THRESHOLD) begin
			prdata = {{(32-SCORE_W){1'b0}}, thr_q};
		end
	end

	// pipeline links: index k is the hand-off into CORDIC stage k (or the back end)
	logic       v_c    [0:CORDIC_STAGES];
	logic       rdy_c  [0:CORDIC_STAGES];
	rtbd_rot_t  rot_c  [0:CORDIC_STAGES];
	rtbd_meta_t meta_c [0:CORDIC_STAGES];

	rtbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_in   (cell_in),
		.thr       (thr_q),
		.out_valid (v_c[0]),
		.out_rot   (rot_c[0]),
		.out_meta  (meta_c[0]),
		.out_ready (rdy_c[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		rtbd_cordic_stage #(
			.FIRST_ITER (g * CORDIC_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[g]),
			.in_rot    (rot_c[g]),
			.in_meta   (meta_c[g]),
			.in_ready  (rdy_c[g]),
			.out_valid (v_c[g+1]),
			.out_rot   (rot_c[g+1]),
			.out_meta  (meta_c[g+1]),
			.out_ready (rdy_c[g+1])
		);
	end

	rtbd_back #(
		.CELL_STRIDE (CELL_STRIDE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c[CORDIC_STAGES]),
		.in_rot   (rot_c[CORDIC_STAGES]),
		.in_meta  (meta_c[CORDIC_STAGES]),
		.in_ready (rdy_c[CORDIC_STAGES]),
		.box_out  (box_out)
	);

	// a delivered box always passed the score gate
	`RTBD_ASSERT_NOW(a_kept_above_thr, box_out.valid, box_out.kept_score >= thr_q, "box below threshold")
	// an empty output register means the whole pipe can move
	`RTBD_ASSERT_NOW(a_ready_when_drained, !box_out.valid, cell_in.ready, "input stalled with empty output")
	// threshold write lands on the next edge
	`RTBD_ASSERT_NEXT(a_thr_write, cfg_wr, thr_q == $past(pwdata[SCORE_W-1:0]), "threshold write lost")

endmodule

`default_nettype wire
